/* rtl/xcfr_pkg.sv */
// Package for the XOR-checked frame reassembler.
// Holds the frame-format constants and the reset value of the length limit.
// Used by the top level and by its port checker. It depends on nothing.
`default_nettype none

package xcfr_pkg;

  // Frame format: opcode, length L, L payload bytes, XOR checksum.
  localparam int FRAME_OVERHEAD = 3;   // opcode + length + checksum
  localparam int MIN_HELD       = 4;   // shortest frame that can be checked
  localparam int MAX_RESULTS    = 32;  // frame bytes reported per input byte

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int TDATA_OUT = 16;       // frame_byte + frame_length, byte padded

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd24;

endpackage : xcfr_pkg

`default_nettype wire

/* rtl/xcfr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data updates only on a read enable and holds otherwise.
// No dependencies.
`default_nettype none

module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire                       re,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : xcfr_ram

`default_nettype wire

/* rtl/xor_checked_frame_reassembler.sv */
// XOR-checked frame reassembler. Received bytes (one per slave transaction)
// are collected in a circular byte store of BUF_BYTES entries; after each byte
// the store is scanned for frames of the form opcode, length L, L payload
// bytes, XOR checksum (total L+3 bytes). A frame that checks out goes out on
// the master side one byte per transaction, tlast on the checksum byte, with
// its total length alongside; an implausible length (zero, or a total L+3 above the
// max_frame_len register) or a bad checksum drops the front byte and the scan
// goes on. A byte that arrives on a full store empties it first. One byte is
// worked on at a time: s_tready is high only between scans. All work goes
// through the single read port of the byte store: each access is a fetch
// state (ST_CHK, ST_XRD, ST_ERD) followed by the state that uses the byte.
// Emitting a byte waits on any master-side stall. Past MAX_RESULTS frame
// bytes per received byte, further bytes are removed but not reported.
// Results go through an output register, so the next byte may be accepted
// while the last frame byte still waits.
// Depends on xcfr_pkg and xcfr_ram.
`default_nettype none

module xor_checked_frame_reassembler #(
  parameter int BUF_BYTES = 32   // byte store depth, 8 to 256
) (
  input  wire         clk,
  input  wire         rst,
  // slave side: received bytes
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tlast,   // chunk_last, informational, not used
  // master side: checked frame bytes
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [7:0] frame_byte, [13:8] frame_length, [15:14] 0
  output logic        m_tlast,   // frame_last
  // max_frame_len register
  input  wire         cfg_we,
  input  wire  [5:0]  cfg_wdata
);

  localparam int AW = $clog2(BUF_BYTES);         // store address
  localparam int SW = AW + 1;                    // address sum before wrap
  localparam int CW = $clog2(BUF_BYTES + 1);     // fill count, holds BUF_BYTES
  localparam int LW = (CW > 9) ? CW : 9;         // length compares
  localparam int PW = $clog2(xcfr_pkg::MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a byte
    ST_CHK,    // enough bytes? fetch length byte
    ST_LEN,    // judge length
    ST_XRD,    // fetch byte for checksum
    ST_XAC,    // fold byte into checksum
    ST_ERD,    // fetch front byte for output
    ST_EWR     // hand front byte to output register
  } state_t;

  state_t                      state;
  logic [AW-1:0]               head;     // store address of the front byte
  logic [CW-1:0]               fill;     // bytes held
  logic [CW-1:0]               idx;      // checksum offset / bytes left to emit
  logic [xcfr_pkg::LEN_W-1:0]  total;    // length of frame under work
  logic [xcfr_pkg::BYTE_W-1:0] acc;      // running XOR
  logic [PW-1:0]               produced; // frame bytes reported for this byte
  logic [xcfr_pkg::LEN_W-1:0]  max_len;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [xcfr_pkg::BYTE_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [SW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SW'(BUF_BYTES)) begin
      s = s - SW'(BUF_BYTES);
    end
    return s[AW-1:0];
  endfunction

  logic          full;
  logic [AW-1:0] head_inc;
  logic [LW-1:0] tot_w;       // L + 3 from the length byte
  logic          len_bad;
  logic          len_short;
  logic [7:0]    acc_new;
  logic          out_free;
  logic          emit;        // front byte goes into the output register

  assign full      = (fill == CW'(BUF_BYTES));
  assign head_inc  = add_wrap(head, AW'(1));
  assign tot_w     = LW'(ram_rdata) + LW'(xcfr_pkg::FRAME_OVERHEAD);
  assign len_bad   = (ram_rdata == '0) || (tot_w > LW'(max_len));
  assign len_short = (LW'(fill) < tot_w);
  assign acc_new   = acc ^ ram_rdata;
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == ST_EWR) && out_free &&
                     (produced != PW'(xcfr_pkg::MAX_RESULTS));

  assign s_tready  = (state == ST_IDLE);

  // Store write happens only on byte arrival, so it never meets a scan read.
  assign ram_we    = s_tvalid && s_tready;
  assign ram_waddr = full ? head : add_wrap(head, fill[AW-1:0]);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = head;
    case (state)
      ST_CHK: begin
        ram_re    = 1'b1;
        ram_raddr = head_inc;
      end
      ST_XRD: begin
        ram_re    = 1'b1;
        ram_raddr = add_wrap(head, idx[AW-1:0]);
      end
      ST_ERD: begin
        ram_re    = 1'b1;
        ram_raddr = head;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = head;
      end
    endcase
  end

  xcfr_ram #(
    .WIDTH (xcfr_pkg::BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= xcfr_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      fill     <= '0;
      produced <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output register: loaded by a frame byte, emptied by a transaction
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            // full store: empty it, the new byte becomes the front
            fill     <= full ? CW'(1) : fill + CW'(1);
            produced <= '0;
            state    <= ST_CHK;
          end
        end
        ST_CHK: begin
          state <= (fill < CW'(xcfr_pkg::MIN_HELD)) ? ST_IDLE : ST_LEN;
        end
        ST_LEN: begin
          if (len_bad) begin
            head  <= head_inc;
            fill  <= fill - CW'(1);
            state <= ST_CHK;
          end else if (len_short) begin
            state <= ST_IDLE;       // frame not complete yet
          end else begin
            total <= tot_w[xcfr_pkg::LEN_W-1:0];
            idx   <= '0;
            acc   <= '0;
            state <= ST_XRD;
          end
        end
        ST_XRD: begin
          state <= ST_XAC;
        end
        ST_XAC: begin
          acc <= acc_new;
          // XOR over all bytes including the checksum is zero on a match
          if (LW'(idx) + LW'(1) == LW'(total)) begin
            if (acc_new == '0) begin
              idx   <= CW'(total);
              state <= ST_ERD;
            end else begin
              head  <= head_inc;
              fill  <= fill - CW'(1);
              state <= ST_CHK;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_XRD;
          end
        end
        ST_ERD: begin
          state <= ST_EWR;
        end
        ST_EWR: begin
          // past the result limit the byte is removed but not reported
          if (produced == PW'(xcfr_pkg::MAX_RESULTS) || out_free) begin
            if (emit) begin
              m_tdata[7:0]  <= ram_rdata;
              m_tdata[13:8] <= total;
              m_tdata[15:14] <= '0;
              m_tlast       <= (idx == CW'(1));
              produced      <= produced + PW'(1);
            end
            head  <= head_inc;
            fill  <= fill - CW'(1);
            idx   <= idx - CW'(1);
            state <= (idx == CW'(1)) ? ST_CHK : ST_ERD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : xor_checked_frame_reassembler

`default_nettype wire

/* rtl/xcfr_checker.sv */
// Port-level checker for the XOR-checked frame reassembler, with its bind.
// Watches only the top-level ports. Depends on xcfr_pkg.
`default_nettype none

module xcfr_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire        m_tlast
);

  // one byte is scanned at a time: input closes right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted during a scan");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_len_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:8] >= 6'(xcfr_pkg::MIN_HELD)) && (m_tdata[15:14] == 2'b00))
    else $error("frame length out of range");

  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
      m_tdata[13:8] == $past(m_tdata[13:8]))
    else $error("frame length changed within a frame");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule : xcfr_checker

bind xor_checked_frame_reassembler xcfr_checker u_xcfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
